// ===== sv/eaq_pkg.sv =====
// Package for the Euler-angle to quaternion block: widths, CORDIC tables
// and fixed-point helpers. No dependencies.
package eaq_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int COMPONENT_BITS = 16;
  localparam int CORDIC_STEPS = 30;
  // Q2.30 plus guard bits for the CORDIC datapath
  localparam int CW = 34;
  // product accumulator width
  localparam int PW = 2 * CW;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam int OUT_SHIFT = 31 - COMPONENT_BITS;

  typedef logic signed [CW-1:0] fix_t;
  typedef logic signed [COMPONENT_BITS-1:0] comp_t;
  typedef logic signed [ANGLE_BITS-1:0] angle_t;

  typedef struct packed {
    fix_t cx;
    fix_t sy;
    fix_t rest;
  } cordic_t;

  function automatic fix_t atan_step(input int i);
    fix_t t;
    case (i)
      0: t = 34'sd536870912;  1: t = 34'sd316933406;  2: t = 34'sd167458907;
      3: t = 34'sd85004756;   4: t = 34'sd42667331;   5: t = 34'sd21354465;
      6: t = 34'sd10679838;   7: t = 34'sd5340245;    8: t = 34'sd2670163;
      9: t = 34'sd1335087;    10: t = 34'sd667544;    11: t = 34'sd333772;
      12: t = 34'sd166886;    13: t = 34'sd83443;     14: t = 34'sd41722;
      15: t = 34'sd20861;     16: t = 34'sd10430;     17: t = 34'sd5215;
      18: t = 34'sd2608;      19: t = 34'sd1304;      20: t = 34'sd652;
      21: t = 34'sd326;       22: t = 34'sd163;       23: t = 34'sd81;
      24: t = 34'sd41;        25: t = 34'sd20;        26: t = 34'sd10;
      27: t = 34'sd5;         28: t = 34'sd3;         29: t = 34'sd1;
      default: t = '0;
    endcase
    return t;
  endfunction

  // One CORDIC rotation step (arithmetic shift is a floor shift)
  function automatic cordic_t cordic_step(input cordic_t c, input int i);
    cordic_t r;
    fix_t dx;
    fix_t dy;
    dx = c.sy >>> i;
    dy = c.cx >>> i;
    if (!c.rest[CW-1]) begin
      r.cx = c.cx - dx;
      r.sy = c.sy + dy;
      r.rest = c.rest - atan_step(i);
    end else begin
      r.cx = c.cx + dx;
      r.sy = c.sy - dy;
      r.rest = c.rest + atan_step(i);
    end
    return r;
  endfunction

  // Q2.30 product, round to nearest with ties up
  function automatic fix_t fix_mul(input fix_t a, input fix_t b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b) + (PW'(1) <<< 29);
    return CW'(p >>> 30);
  endfunction

  function automatic comp_t to_component(input fix_t v);
    fix_t r;
    r = (v + (CW'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (r > CW'((1 <<< (COMPONENT_BITS - 1)) - 1))
      return comp_t'((1 <<< (COMPONENT_BITS - 1)) - 1);
    if (r < -(CW'(1) <<< (COMPONENT_BITS - 1)))
      return comp_t'(-(1 <<< (COMPONENT_BITS - 1)));
    return comp_t'(r);
  endfunction

endpackage

// ===== sv/euler_angles_to_quaternion_top.sv =====
// Euler angles (Z-Y-X) to unit quaternion, fully pipelined.
// Pipeline registers from accepted input word to output word valid: seed reg,
// 30 CORDIC stages, pair product, triple product, sum, round/out reg.
// Throughput: one word per cycle; the whole pipe advances only when the
// output register is free or being drained.
// Reset: rst (synchronous) clears all valid bits; data registers are not reset.
// Depends on eaq_pkg.
module euler_angles_to_quaternion_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid_in,
  output logic        ready_in,
  input  eaq_pkg::angle_t roll_angle,
  input  eaq_pkg::angle_t pitch_angle,
  input  eaq_pkg::angle_t yaw_angle,
  output logic        valid_out,
  input  logic        ready_out,
  output eaq_pkg::comp_t quat_w,
  output eaq_pkg::comp_t quat_x,
  output eaq_pkg::comp_t quat_y,
  output eaq_pkg::comp_t quat_z
);

  localparam int N = eaq_pkg::CORDIC_STEPS;
  localparam int CW = eaq_pkg::CW;

  // advance the whole pipe when the output word is free or taken now
  logic adv;
  assign adv = !valid_out || ready_out;
  assign ready_in = adv;

  // CORDIC stage registers: stage k holds the result after k steps
  eaq_pkg::cordic_t cr [N+1];
  eaq_pkg::cordic_t cp [N+1];
  eaq_pkg::cordic_t cy [N+1];
  logic [N:0] cv;

  function automatic eaq_pkg::cordic_t seed(input eaq_pkg::angle_t a);
    eaq_pkg::cordic_t s;
    s.cx = eaq_pkg::CORDIC_GAIN;
    s.sy = '0;
    // half angle in units of 2^32 per turn
    s.rest = CW'(a) <<< (31 - eaq_pkg::ANGLE_BITS);
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) cv <= '0;
    else if (adv) cv <= {cv[N-1:0], valid_in};
    if (adv) begin
      cr[0] <= seed(roll_angle);
      cp[0] <= seed(pitch_angle);
      cy[0] <= seed(yaw_angle);
      for (int k = 0; k < N; k++) begin
        cr[k+1] <= eaq_pkg::cordic_step(cr[k], k);
        cp[k+1] <= eaq_pkg::cordic_step(cp[k], k);
        cy[k+1] <= eaq_pkg::cordic_step(cy[k], k);
      end
    end
  end

  // Pair products: a=c/s roll, b=c/s pitch; four combinations plus yaw
  eaq_pkg::fix_t p_cc, p_cs, p_sc, p_ss, ycos, ysin;
  logic v1;
  eaq_pkg::fix_t t_ccc, t_sss, t_scc, t_css, t_csc, t_scs, t_ccs, t_ssc;
  logic v2;
  eaq_pkg::fix_t q_w, q_x, q_y, q_z;
  logic v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      valid_out <= 1'b0;
    end else if (adv) begin
      v1 <= cv[N];
      v2 <= v1;
      v3 <= v2;
      valid_out <= v3;
    end
    if (adv) begin
      p_cc <= eaq_pkg::fix_mul(cr[N].cx, cp[N].cx);
      p_cs <= eaq_pkg::fix_mul(cr[N].cx, cp[N].sy);
      p_sc <= eaq_pkg::fix_mul(cr[N].sy, cp[N].cx);
      p_ss <= eaq_pkg::fix_mul(cr[N].sy, cp[N].sy);
      ycos <= cy[N].cx;
      ysin <= cy[N].sy;
      t_ccc <= eaq_pkg::fix_mul(p_cc, ycos);
      t_sss <= eaq_pkg::fix_mul(p_ss, ysin);
      t_scc <= eaq_pkg::fix_mul(p_sc, ycos);
      t_css <= eaq_pkg::fix_mul(p_cs, ysin);
      t_csc <= eaq_pkg::fix_mul(p_cs, ycos);
      t_scs <= eaq_pkg::fix_mul(p_sc, ysin);
      t_ccs <= eaq_pkg::fix_mul(p_cc, ysin);
      t_ssc <= eaq_pkg::fix_mul(p_ss, ycos);
      q_w <= t_ccc + t_sss;
      q_x <= t_scc - t_css;
      q_y <= t_csc + t_scs;
      q_z <= t_ccs - t_ssc;
      quat_w <= eaq_pkg::to_component(q_w);
      quat_x <= eaq_pkg::to_component(q_x);
      quat_y <= eaq_pkg::to_component(q_y);
      quat_z <= eaq_pkg::to_component(q_z);
    end
  end

endmodule

// ===== verif/euler_angles_to_quaternion_checker.sv =====
// Checker for the Euler-angle to quaternion block: watches both channels,
// predicts each quaternion with its own CORDIC model and compares. Uses eaq_pkg.
`timescale 1ns / 1ps
module euler_angles_to_quaternion_checker (
  input  logic clk,
  input  logic rst,
  input  logic valid_in,
  input  logic ready_in,
  input  logic signed [15:0] roll_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] yaw_angle,
  input  logic valid_out,
  input  logic ready_out,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output int   mismatches,
  output int   pending
);

  typedef struct packed {
    eaq_pkg::comp_t w;
    eaq_pkg::comp_t x;
    eaq_pkg::comp_t y;
    eaq_pkg::comp_t z;
  } quat_t;

  localparam longint ATAN_TBL [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};

  quat_t expected_quats [$];

  function automatic longint q30_mul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic void half_trig(eaq_pkg::angle_t ang, output longint c,
                                    output longint s);
    longint resid;
    longint dx;
    longint dy;
    c = 652032874;
    s = 0;
    resid = longint'(ang) * (64'sd1 <<< (31 - eaq_pkg::ANGLE_BITS));
    for (int i = 0; i < 30; i++) begin
      dx = s >>> i;
      dy = c >>> i;
      if (resid >= 0) begin
        c -= dx; s += dy; resid -= ATAN_TBL[i];
      end else begin
        c += dx; s -= dy; resid += ATAN_TBL[i];
      end
    end
  endfunction

  function automatic eaq_pkg::comp_t round_sat(longint v);
    longint r;
    r = (v + (64'sd1 <<< (eaq_pkg::OUT_SHIFT - 1))) >>> eaq_pkg::OUT_SHIFT;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return eaq_pkg::comp_t'(r);
  endfunction

  function automatic longint tri3(longint a, longint b, longint c);
    return q30_mul(q30_mul(a, b), c);
  endfunction

  function automatic quat_t predict_quat(eaq_pkg::angle_t r, eaq_pkg::angle_t p,
                                         eaq_pkg::angle_t y);
    longint cr, sr, cp, sp, cy, sy;
    quat_t q;
    half_trig(r, cr, sr);
    half_trig(p, cp, sp);
    half_trig(y, cy, sy);
    q.w = round_sat(tri3(cr, cp, cy) + tri3(sr, sp, sy));
    q.x = round_sat(tri3(sr, cp, cy) - tri3(cr, sp, sy));
    q.y = round_sat(tri3(cr, sp, cy) + tri3(sr, cp, sy));
    q.z = round_sat(tri3(cr, cp, sy) - tri3(sr, sp, cy));
    return q;
  endfunction

  task automatic cmp(string name, eaq_pkg::comp_t e, eaq_pkg::comp_t a);
    if (e !== a) begin
      $error("%s expected %0d actual %0d", name, e, a);
      mismatches++;
    end
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    quat_t e;
    if (!rst) begin
      if (valid_in && ready_in)
        expected_quats.push_back(predict_quat(roll_angle, pitch_angle, yaw_angle));
      if (valid_out && ready_out) begin
        if (expected_quats.size() == 0) begin
          $error("quaternion word with none expected");
          mismatches++;
        end else begin
          e = expected_quats.pop_front();
          cmp("quat_w", e.w, quat_w);
          cmp("quat_x", e.x, quat_x);
          cmp("quat_y", e.y, quat_y);
          cmp("quat_z", e.z, quat_z);
        end
      end
    end
    pending <= expected_quats.size();
  end
endmodule

// ===== verif/euler_angles_to_quaternion_top_test.sv =====
// Top of the Euler-angle to quaternion test: clock, reset, angle stimulus,
// output back-pressure and verdict. Depends on eaq_pkg and the checker.
`timescale 1ns / 1ps
module euler_angles_to_quaternion_top_test;
  logic clk = 0;
  logic rst = 1;
  logic valid_in = 0;
  logic ready_out = 0;
  logic signed [15:0] roll_angle = 0, pitch_angle = 0, yaw_angle = 0;
  logic ready_in, valid_out;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
  int mismatches, pending;
  // receiver mode: 0 random, 1 always ready, 2 hold off
  int rx_mode = 0;

  always #5 clk = ~clk;

  euler_angles_to_quaternion_top u_dut (.*);

  euler_angles_to_quaternion_checker u_chk (.*);

  // Offer one angle word, idle a random gap first when asked; hold until taken.
  task automatic send_word(logic signed [15:0] r, p, y, bit gaps);
    if (gaps) begin
      while ($urandom_range(99) < 37) begin
        valid_in <= 0;
        @(posedge clk);
      end
    end
    valid_in <= 1;
    roll_angle <= r;
    pitch_angle <= p;
    yaw_angle <= y;
    @(posedge clk);
    while (!ready_in) @(posedge clk);
  endtask

  // Pick an angle: mostly uniform, sometimes an extreme, a quarter-turn multiple or a value near zero.
  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(int'($urandom_range(3)) * 16384);
      3: return 16'($urandom_range(7) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  // Drive output back-pressure according to the current receiver mode.
  always @(posedge clk) begin
    if (rx_mode == 1) ready_out <= 1;
    else if (rx_mode == 2) ready_out <= 0;
    else ready_out <= ($urandom_range(99) >= 37);
  end

  initial begin
    logic signed [15:0] edge_vals [8];
    int wait_cnt;
    edge_vals = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001, 16'shffff,
                  16'sh4000, 16'shc000, 16'sh2000};
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: edge values on each axis, then the most negative angle on all three at once.
    for (int i = 0; i < 8; i++) send_word(edge_vals[i], 0, 0, 0);
    for (int i = 0; i < 8; i++) send_word(0, edge_vals[i], 0, 1);
    for (int i = 0; i < 8; i++) send_word(0, 0, edge_vals[i], 1);
    send_word(16'sh8000, 16'sh8000, 16'sh8000, 0);
    // Pause the sender until every expected quaternion has drained.
    valid_in <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // Random with idling on both sides.
    for (int n = 0; n < 300; n++) send_word(rand_angle(), rand_angle(), rand_angle(), 1);
    // Stretch with no idling on either side.
    rx_mode = 1;
    for (int n = 0; n < 150; n++) send_word(rand_angle(), rand_angle(), rand_angle(), 0);
    // Hold off the receiver long enough that the pipe fills and stalls input.
    rx_mode = 2;
    fork
      begin
        wait_cnt = 0;
        while (wait_cnt < 200) begin
          @(posedge clk);
          wait_cnt++;
        end
        rx_mode = 0;
      end
      for (int n = 0; n < 100; n++) send_word(rand_angle(), rand_angle(), rand_angle(), 0);
    join
    for (int n = 0; n < 200; n++) send_word(rand_angle(), rand_angle(), rand_angle(), 1);
    // Drain, then allow the pipeline latency to pass for stray words.
    valid_in <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
